// ===== hdl/zcaf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcaf_pkg
// Shared types, codes and the blend function of the zone colour averager.
// ----------------------------------------------------------------------------
package zcaf_pkg;

    localparam int SAMPLES_PER_ZONE = 256;
    localparam int SUM_W            = 16;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 8;

    localparam logic [7:0] SAMPLE_LAST = 8'(SAMPLES_PER_ZONE - 1);
    localparam logic [7:0] HDR_FIRST   = 8'h6F;   // 'o'
    localparam logic [7:0] HDR_SECOND  = 8'h7A;   // 'z'

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FADE_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 1'b1;

    // byte position within one output run
    localparam logic [2:0] POS_HDR0  = 3'd0;
    localparam logic [2:0] POS_HDR1  = 3'd1;
    localparam logic [2:0] POS_RED   = 3'd2;
    localparam logic [2:0] POS_GREEN = 3'd3;
    localparam logic [2:0] POS_BLUE  = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_run;
        logic       frame_done;
    } out_t;

    // (avg*(255-f) + prev*f) >> 8; the sum never exceeds 255*255
    function automatic logic [7:0] blend(input logic [7:0] avg,
                                         input logic [7:0] prev,
                                         input logic [7:0] f);
        logic [16:0] acc;
        acc = 17'({8'd0, avg} * (16'd255 - {8'd0, f})) + 17'({8'd0, prev} * {8'd0, f});
        return acc[15:8];
    endfunction

endpackage

// ===== hdl/zone_colour_average_fade.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zone_colour_average_fade
// Per-zone pixel averager with temporal fade against a stored zone colour.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  in        sink       in_valid / in_stall     in_data (red, green, blue)
//  out       source     out_valid / out_stall   out_data (byte, last, done)
//  cfg       sink       cfg_wr_en               cfg_index, cfg_data
//
//  One pixel transfer per cycle while in_stall is low. A zone-ending pixel
//  reads the colour store (synchronous read), the next cycle blends and writes
//  back, and the run of 3 bytes (5 with the 'o','z' header on zone 0) drains
//  one a cycle while out_stall is low. The input stalls only on a zone-ending
//  pixel while the previous run has not fully drained; no other pixel ever stalls.
//  Reset clears per-entry valid bits at once; no clearing pass is needed.
//
module zone_colour_average_fade #(
    parameter int MAX_ZONES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  zcaf_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output zcaf_pkg::out_t                   out_data,
    input  logic                             cfg_wr_en,
    input  logic [zcaf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [zcaf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import zcaf_pkg::*;

    // zone index width, and a compare width that holds led_count and MAX_ZONES
    localparam int ZW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CMP_W = (ZW + 1 > 7) ? ZW + 1 : 7;
    localparam logic [CMP_W-1:0] ZONE_MAX = CMP_W'(MAX_ZONES);

    // configuration
    logic [7:0]       fade_weight_reg;
    logic [6:0]       led_count_reg;

    // accumulation stage
    logic [7:0]       sample_cnt_reg;
    logic [ZW-1:0]    zone_index_reg;
    logic [SUM_W-1:0] sum_red_reg, sum_green_reg, sum_blue_reg;
    logic [SUM_W-1:0] sum_red_next, sum_green_next, sum_blue_next;

    // blend stage (valid the cycle after a zone ends)
    logic             s1_valid_reg;
    logic [ZW-1:0]    s1_zi_reg;
    logic             s1_hdr_reg;
    logic             s1_done_reg;
    logic [7:0]       s1_fade_reg;
    logic [7:0]       s1_avg_r_reg, s1_avg_g_reg, s1_avg_b_reg;

    // colour store
    logic [23:0]          mem [MAX_ZONES];
    logic [23:0]          rd_data_reg;
    logic [MAX_ZONES-1:0] ent_valid_reg;
    logic [23:0]          prev_colour;
    logic [23:0]          new_colour;

    // output run buffer
    logic             busy_reg;
    logic [2:0]       pos_reg;
    logic             res_done_reg;
    logic [7:0]       res_r_reg, res_g_reg, res_b_reg;

    logic             in_fire, out_fire, zone_end;
    logic [CMP_W-1:0] led_ext, zone_cnt, zi_plus;
    logic             done_now;
    logic [ZW-1:0]    zone_index_next;

    assign zone_end = (sample_cnt_reg == SAMPLE_LAST);
    assign in_stall = zone_end && busy_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    assign sum_red_next   = sum_red_reg   + SUM_W'(in_data.red);
    assign sum_green_next = sum_green_reg + SUM_W'(in_data.green);
    assign sum_blue_next  = sum_blue_reg  + SUM_W'(in_data.blue);

    // effective zone count: zero means one, clamp at MAX_ZONES
    always_comb
    begin
        led_ext = CMP_W'(led_count_reg);
        if (led_ext == '0)
            zone_cnt = CMP_W'(1);
        else if (led_ext > ZONE_MAX)
            zone_cnt = ZONE_MAX;
        else
            zone_cnt = led_ext;
        zi_plus         = CMP_W'(zone_index_reg) + CMP_W'(1);
        done_now        = (zi_plus >= zone_cnt);
        zone_index_next = done_now ? '0 : zi_plus[ZW-1:0];
    end

    // stored colour of a never-written zone reads as zero
    assign prev_colour = ent_valid_reg[s1_zi_reg] ? rd_data_reg : 24'd0;
    assign new_colour  = {blend(s1_avg_r_reg, prev_colour[23:16], s1_fade_reg),
                          blend(s1_avg_g_reg, prev_colour[15:8],  s1_fade_reg),
                          blend(s1_avg_b_reg, prev_colour[7:0],   s1_fade_reg)};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_weight_reg <= '0;
            led_count_reg   <= 7'd60;
            sample_cnt_reg  <= '0;
            zone_index_reg  <= '0;
            sum_red_reg     <= '0;
            sum_green_reg   <= '0;
            sum_blue_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            ent_valid_reg   <= '0;
            busy_reg        <= 1'b0;
            pos_reg         <= POS_RED;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FADE_WEIGHT: fade_weight_reg <= cfg_data;
                    REG_LED_COUNT:   led_count_reg   <= cfg_data[6:0];
                    default:         ;
                endcase
            end

            s1_valid_reg <= in_fire && zone_end;
            if (in_fire)
            begin
                if (zone_end)
                begin
                    sample_cnt_reg <= '0;
                    sum_red_reg    <= '0;
                    sum_green_reg  <= '0;
                    sum_blue_reg   <= '0;
                    zone_index_reg <= zone_index_next;
                end
                else
                begin
                    sample_cnt_reg <= sample_cnt_reg + 8'd1;
                    sum_red_reg    <= sum_red_next;
                    sum_green_reg  <= sum_green_next;
                    sum_blue_reg   <= sum_blue_next;
                end
            end

            // a zone end waits until the previous run drains, so a load never
            // meets a drain
            if (s1_valid_reg)
            begin
                ent_valid_reg[s1_zi_reg] <= 1'b1;
                busy_reg <= 1'b1;
                pos_reg  <= s1_hdr_reg ? POS_HDR0 : POS_RED;
            end
            else if (out_fire)
            begin
                if (pos_reg == POS_BLUE)
                    busy_reg <= 1'b0;
                else
                    pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire && zone_end)
        begin
            s1_zi_reg    <= zone_index_reg;
            s1_hdr_reg   <= (zone_index_reg == '0);
            s1_done_reg  <= done_now;
            s1_fade_reg  <= fade_weight_reg;
            s1_avg_r_reg <= sum_red_next[15:8];
            s1_avg_g_reg <= sum_green_next[15:8];
            s1_avg_b_reg <= sum_blue_next[15:8];
        end
        if (s1_valid_reg)
        begin
            res_r_reg    <= new_colour[23:16];
            res_g_reg    <= new_colour[15:8];
            res_b_reg    <= new_colour[7:0];
            res_done_reg <= s1_done_reg;
        end
    end

    // colour store: read on the zone-ending transfer, write back in the next cycle.
    // Accesses to one entry are a whole zone of transfers apart, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (in_fire && zone_end)
            rd_data_reg <= mem[zone_index_reg];
        if (s1_valid_reg)
            mem[s1_zi_reg] <= new_colour;
    end

    // output byte selection
    always_comb
    begin
        case (pos_reg)
            POS_HDR0:  out_data.data_byte = HDR_FIRST;
            POS_HDR1:  out_data.data_byte = HDR_SECOND;
            POS_RED:   out_data.data_byte = res_r_reg;
            POS_GREEN: out_data.data_byte = res_g_reg;
            default:   out_data.data_byte = res_b_reg;
        endcase
        out_data.last_of_run = (pos_reg == POS_BLUE);
        out_data.frame_done  = (pos_reg == POS_BLUE) && res_done_reg;
    end

    assign out_valid = busy_reg;

endmodule

// ===== hdl/zcaf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcaf_checker
// Port-level checks on the output run and input stall of the zone averager.
// ----------------------------------------------------------------------------
module zcaf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input zcaf_pkg::out_t                   out_data
);
    import zcaf_pkg::*;

    // stalled output holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output changed");

    // a run continues until its last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_of_run |=> out_valid)
        else $error("output run broken");

    // a new run never starts right after the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.last_of_run |=> !out_valid)
        else $error("run restarted too early");

    // input stalls only while a run is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending run");

    // frame end marks only the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_done |-> out_data.last_of_run)
        else $error("frame_done off the last byte");

endmodule

bind zone_colour_average_fade zcaf_checker u_zcaf_checker (.*);
